// ===== hw/rtl/mrx_pkg.sv =====
// mrx_pkg: types, widths and constants for the 4x4 row multiplier.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package mrx_pkg;

  // Number format and port geometry
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned N_LANES    = 4;
  localparam int unsigned ROW_W      = $clog2(N_LANES);

  // Full-precision widths: one product, a pair sum, the four-term sum
  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MUL  = 1'b1
  } op_e;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef elem_t                         elem_row_t [N_LANES];
  typedef logic [ELEM_W-1:0]             word_t;
  typedef word_t                         word_row_t [N_LANES];
  typedef logic [ROW_W-1:0]              row_idx_t;

  // Stage load enables shared by all lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage : mrx_pkg

// ===== hw/rtl/mrx_row_store.sv =====
// mrx_row_store: register file holding the right-hand 4x4 matrix.
// Written a row per load transaction, read a column per lane. Uses mrx_pkg.
`timescale 1ns / 1ps

module mrx_row_store (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  mrx_pkg::row_idx_t wr_row_i,
  input  mrx_pkg::elem_t    wr_data_i [mrx_pkg::N_LANES],
  output mrx_pkg::elem_t    col_o     [mrx_pkg::N_LANES][mrx_pkg::N_LANES]
);
  import mrx_pkg::*;

  elem_t mat_q [N_LANES][N_LANES];

  // No reset: contents are meaningless until loaded
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int c = 0; c < N_LANES; c++) begin
        mat_q[wr_row_i][c] <= wr_data_i[c];
      end
    end
  end

  // col_o[j][k] = R[k][j]
  always_comb begin
    for (int j = 0; j < N_LANES; j++) begin
      for (int k = 0; k < N_LANES; k++) begin
        col_o[j][k] = mat_q[k][j];
      end
    end
  end

endmodule : mrx_row_store

// ===== hw/rtl/mrx_lane.sv =====
// mrx_lane: one product column - four multiplies, a two-level adder tree,
// then shift and saturation. Uses mrx_pkg.
`timescale 1ns / 1ps

module mrx_lane (
  input  logic              clk_i,
  input  mrx_pkg::pipe_en_t en_i,
  input  mrx_pkg::elem_t    l_row_i [mrx_pkg::N_LANES],
  input  mrx_pkg::elem_t    r_col_i [mrx_pkg::N_LANES],
  output mrx_pkg::word_t    prod_o,
  output logic              clamp_o
);
  import mrx_pkg::*;

  logic signed [PROD_W-1:0] mul_q  [N_LANES];
  logic signed [PAIR_W-1:0] pair_q [2];
  logic signed [SUM_W-1:0]  sum_q;

  logic [SUM_W-FRAC_BITS-DATA_WIDTH:0] hi_bits;
  logic                                fits;
  elem_t                               sat_val;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int k = 0; k < N_LANES; k++) begin
        mul_q[k] <= PROD_W'(l_row_i[k]) * PROD_W'(r_col_i[k]);
      end
    end
    if (en_i.s2) begin
      pair_q[0] <= PAIR_W'(mul_q[0]) + PAIR_W'(mul_q[1]);
      pair_q[1] <= PAIR_W'(mul_q[2]) + PAIR_W'(mul_q[3]);
    end
    if (en_i.s3) begin
      sum_q <= SUM_W'(pair_q[0]) + SUM_W'(pair_q[1]);
    end
  end

  // After the arithmetic shift the value fits when every bit above the
  // result's sign bit agrees with it
  always_comb begin
    hi_bits = sum_q[SUM_W-1:FRAC_BITS+DATA_WIDTH-1];
    fits    = (&hi_bits) || !(|hi_bits);
    if (fits) begin
      sat_val = sum_q[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
    end else if (sum_q[SUM_W-1]) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = SAT_MAX;
    end
  end

  assign prod_o  = ELEM_W'(sat_val);
  assign clamp_o = !fits;

endmodule : mrx_lane

// ===== hw/rtl/mrx_merge.sv =====
// mrx_merge: output register - gathers the lane results, merges the clamp
// flags and holds the transaction while the consumer stalls. Uses mrx_pkg.
`timescale 1ns / 1ps

module mrx_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  mrx_pkg::row_idx_t  row_i,
  input  mrx_pkg::word_t     prod_i  [mrx_pkg::N_LANES],
  input  logic               clamp_i [mrx_pkg::N_LANES],
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mrx_pkg::row_idx_t  out_row_o,
  output mrx_pkg::word_t     prod_o  [mrx_pkg::N_LANES],
  output logic               saturated_o
);
  import mrx_pkg::*;

  logic      valid_q, valid_d;
  row_idx_t  row_q;
  word_t     prod_q [N_LANES];
  logic      sat_q, sat_d;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    sat_d = 1'b0;
    for (int j = 0; j < N_LANES; j++) begin
      sat_d = sat_d | clamp_i[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      row_q  <= row_i;
      prod_q <= prod_i;
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_row_o   = row_q;
  assign prod_o      = prod_q;
  assign saturated_o = sat_q;

endmodule : mrx_merge

// ===== hw/rtl/matrix4x4_row_multiply_core.sv =====
// Multiplies rows of a left-hand 4x4 matrix by a stored right-hand matrix,
// signed Q16.16 with saturation. Uses mrx_pkg and the mrx_* submodules.
`timescale 1ns / 1ps

// A load transaction (operation 0) writes one row of the right-hand matrix
// and returns nothing; a multiply transaction that follows in the very next
// cycle already sees it. A multiply transaction (operation 1) returns the
// matching product row: the sixteen multipliers work in the accepting cycle,
// the two adder levels of each column are registered one after the other,
// and then the output register, where saturation and the clamp flag are
// resolved, loads. Four lanes, one per output column, run in parallel, so
// one row is taken every cycle; input stall only rises once every pipeline
// stage and the output register are full and the consumer is stalling. No
// clearing pass after reset: products are meaningless until every row read
// has been loaded.

module matrix4x4_row_multiply_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [1:0]            row_index_i,
  input  logic signed [31:0]    elem_0_i,
  input  logic signed [31:0]    elem_1_i,
  input  logic signed [31:0]    elem_2_i,
  input  logic signed [31:0]    elem_3_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            out_row_o,
  output logic signed [31:0]    prod_0_o,
  output logic signed [31:0]    prod_1_o,
  output logic signed [31:0]    prod_2_o,
  output logic signed [31:0]    prod_3_o,
  output logic                  saturated_o
);
  import mrx_pkg::*;

  elem_t     l_row   [N_LANES];
  elem_t     r_cols  [N_LANES][N_LANES];
  word_t     lane_prod  [N_LANES];
  logic      lane_clamp [N_LANES];
  word_t     out_prod   [N_LANES];

  logic      v1_q, v2_q, v3_q;
  logic      v1_d, v2_d, v3_d;
  row_idx_t  row1_q, row2_q, row3_q;
  logic      r1, r2, r3, merge_ready;
  logic      accept, load_acc;
  pipe_en_t  pipe_en;

  // Low DATA_WIDTH bits of each element, taken as two's complement
  assign l_row[0] = elem_0_i[DATA_WIDTH-1:0];
  assign l_row[1] = elem_1_i[DATA_WIDTH-1:0];
  assign l_row[2] = elem_2_i[DATA_WIDTH-1:0];
  assign l_row[3] = elem_3_i[DATA_WIDTH-1:0];

  // Ready chain: a stage moves when empty or when the next one moves
  assign r3 = !v3_q || merge_ready;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;

  assign in_stall_o = !r1;
  assign accept     = in_valid_i && r1;
  assign load_acc   = accept && (op_e'(operation_i) == OP_LOAD);

  assign pipe_en.s1 = r1;
  assign pipe_en.s2 = r2;
  assign pipe_en.s3 = r3;

  assign v1_d = r1 ? (accept && (op_e'(operation_i) == OP_MUL)) : v1_q;
  assign v2_d = r2 ? v1_q : v2_q;
  assign v3_d = r3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      row1_q <= row_index_i;
    end
    if (r2) begin
      row2_q <= row1_q;
    end
    if (r3) begin
      row3_q <= row2_q;
    end
  end

  mrx_row_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (load_acc),
    .wr_row_i  (row_index_i),
    .wr_data_i (l_row),
    .col_o     (r_cols)
  );

  for (genvar j = 0; j < N_LANES; j++) begin : g_lane
    mrx_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .l_row_i (l_row),
      .r_col_i (r_cols[j]),
      .prod_o  (lane_prod[j]),
      .clamp_o (lane_clamp[j])
    );
  end

  mrx_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v3_q),
    .row_i       (row3_q),
    .prod_i      (lane_prod),
    .clamp_i     (lane_clamp),
    .ready_o     (merge_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_row_o   (out_row_o),
    .prod_o      (out_prod),
    .saturated_o (saturated_o)
  );

  assign prod_0_o = out_prod[0];
  assign prod_1_o = out_prod[1];
  assign prod_2_o = out_prod[2];
  assign prod_3_o = out_prod[3];

endmodule : matrix4x4_row_multiply_core

// ===== tb/tb.sv =====
// Self-checking testbench for matrix4x4_row_multiply_core: directed rows, then random traffic.
// Depends on mrx_pkg and core RTL; expected rows: typed table rows or a local Q16.16 model.
`timescale 1ns / 1ps

module tb;
  import mrx_pkg::*;

  localparam int N_DIR  = 25;
  localparam int N_RAND = 900;

  localparam logic [31:0]  W_ZERO  = 32'h0000_0000;
  localparam logic [31:0]  W_ONE   = 32'h0001_0000;
  localparam logic [31:0]  W_M1    = 32'hFFFF_FFFF;
  localparam logic [31:0]  W_MAX   = SAT_MAX;
  localparam logic [31:0]  W_MIN   = SAT_MIN;
  localparam logic [127:0] NO_WANT = 128'h0;

  localparam logic signed [SUM_W-1:0] SUM_HI = elem_t'(SAT_MAX);
  localparam logic signed [SUM_W-1:0] SUM_LO = elem_t'(SAT_MIN);

  typedef struct packed {
    op_e               op;
    row_idx_t          row;
    logic [0:3][31:0]  el;
    logic              typed;
    logic [0:3][31:0]  want;
    logic              want_sat;
  } stim_row_t;

  typedef struct packed {
    row_idx_t          row;
    logic [0:3][31:0]  prod;
    logic              sat;
  } prod_row_t;

  // Typed expectations only where they follow directly from identity or extreme operands
  localparam stim_row_t DIR_TBL [N_DIR] = '{
    '{OP_LOAD, 2'd0, {W_ONE, W_ZERO, W_ZERO, W_ZERO}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd1, {W_ZERO, W_ONE, W_ZERO, W_ZERO}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd2, {W_ZERO, W_ZERO, W_ONE, W_ZERO}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd3, {W_ZERO, W_ZERO, W_ZERO, W_ONE}, 1'b0, NO_WANT, 1'b0},
    '{OP_MUL, 2'd0, {W_MAX, W_MIN, W_ZERO, W_M1}, 1'b1, {W_MAX, W_MIN, W_ZERO, W_M1}, 1'b0},
    '{OP_MUL, 2'd3, {W_ONE, 32'hFFFF_0000, 32'h1234_5678, 32'h8000_0001}, 1'b1,
      {W_ONE, 32'hFFFF_0000, 32'h1234_5678, 32'h8000_0001}, 1'b0},
    '{OP_LOAD, 2'd1, {4{W_MAX}}, 1'b0, NO_WANT, 1'b0},
    '{OP_MUL, 2'd1, {W_ZERO, W_MAX, W_ZERO, W_ZERO}, 1'b1, {4{W_MAX}}, 1'b1},
    '{OP_MUL, 2'd2, {W_ZERO, W_MIN, W_ZERO, W_ZERO}, 1'b1, {4{W_MIN}}, 1'b1},
    '{OP_MUL, 2'd2, {W_ZERO, 32'h1, W_ZERO, W_ZERO}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd0, {4{W_MIN}}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd1, {4{W_MIN}}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd2, {4{W_MIN}}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd3, {4{W_MIN}}, 1'b0, NO_WANT, 1'b0},
    '{OP_MUL, 2'd3, {4{W_MIN}}, 1'b1, {4{W_MAX}}, 1'b1},
    '{OP_MUL, 2'd0, {4{W_MAX}}, 1'b1, {4{W_MIN}}, 1'b1},
    '{OP_MUL, 2'd1, {4{W_ZERO}}, 1'b1, {4{W_ZERO}}, 1'b0},
    '{OP_MUL, 2'd2, {32'h1, W_ZERO, W_ZERO, W_ZERO}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd2, {32'h1, W_M1, W_ONE, W_ZERO}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd0, {4{32'h1}}, 1'b0, NO_WANT, 1'b0},
    // negative sums round towards minus infinity
    '{OP_MUL, 2'd0, {W_M1, W_ZERO, W_ZERO, W_ZERO}, 1'b0, NO_WANT, 1'b0},
    '{OP_MUL, 2'd2, {W_ZERO, W_ZERO, W_ONE, W_M1}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd1, {32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, W_MAX}, 1'b0, NO_WANT, 1'b0},
    '{OP_LOAD, 2'd3, {32'h0000_C000, 32'hFFFF_4000, W_M1, 32'h0003_0000}, 1'b0, NO_WANT, 1'b0},
    '{OP_MUL, 2'd1, {32'h0001_8000, 32'hFFFF_8000, 32'h0004_0000, 32'hFFFE_0000}, 1'b0,
      NO_WANT, 1'b0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             operation;
  logic [1:0]       row_index;
  logic [0:3][31:0] row_elems;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_row;
  logic [31:0]      prod_0, prod_1, prod_2, prod_3;
  logic             saturated;

  elem_t     rhs_mat [16];
  prod_row_t pending_q [$];
  int        err_cnt = 0;

  matrix4x4_row_multiply_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operation_i (operation),
    .row_index_i (row_index),
    .elem_0_i    (row_elems[0]),
    .elem_1_i    (row_elems[1]),
    .elem_2_i    (row_elems[2]),
    .elem_3_i    (row_elems[3]),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_row_o   (out_row),
    .prod_0_o    (prod_0),
    .prod_1_o    (prod_1),
    .prod_2_o    (prod_2),
    .prod_3_o    (prod_3),
    .saturated_o (saturated)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Full-width dot products, floor shift, clamp to the signed data range
  function automatic prod_row_t predict_row(row_idx_t row, logic [0:3][31:0] lrow);
    prod_row_t                 r;
    logic signed [SUM_W-1:0]   acc;
    longint                    term;
    r.row = row;
    r.sat = 1'b0;
    for (int j = 0; j < 4; j++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        term = longint'($signed(lrow[k])) * longint'(rhs_mat[k * 4 + j]);
        acc  = acc + term;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > SUM_HI) begin
        r.prod[j] = SAT_MAX;
        r.sat     = 1'b1;
      end else if (acc < SUM_LO) begin
        r.prod[j] = SAT_MIN;
        r.sat     = 1'b1;
      end else begin
        r.prod[j] = acc[31:0];
      end
    end
    return r;
  endfunction

  // mode 0: full-range row, 1-2: small values, 3: each element mixed incl. corners
  function automatic logic [31:0] rand_elem(int mode);
    int pick;
    pick = (mode == 3) ? $urandom_range(0, 2) : ((mode == 0) ? 0 : 1);
    case (pick)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: begin
        case ($urandom_range(0, 4))
          0:       return W_MAX;
          1:       return W_MIN;
          2:       return W_ZERO;
          3:       return W_M1;
          default: return W_ONE;
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t s;
    int        gap;
    int        mode;
    bit        burst;
    in_valid  <= 1'b0;
    operation <= OP_LOAD;
    row_index <= '0;
    row_elems <= '0;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst = 1'b0;
    for (int n = 0; n < N_DIR + N_RAND; n++) begin
      if (n < N_DIR) begin
        s = DIR_TBL[n];
      end else begin
        s.op    = ($urandom_range(0, 3) == 0) ? OP_LOAD : OP_MUL;
        s.row   = row_idx_t'($urandom_range(0, 3));
        mode    = $urandom_range(0, 3);
        for (int j = 0; j < 4; j++) s.el[j] = rand_elem(mode);
        s.typed = 1'b0;
      end
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      in_valid  <= 1'b1;
      operation <= s.op;
      row_index <= s.row;
      row_elems <= s.el;
      do @(posedge clk); while (in_stall);
      if (s.op == OP_LOAD) begin
        for (int j = 0; j < 4; j++) rhs_mat[s.row * 4 + j] = s.el[j];
      end else if (s.typed) begin
        pending_q.push_back(prod_row_t'{s.row, s.want, s.want_sat});
      end else begin
        pending_q.push_back(predict_row(s.row, s.el));
      end
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("matrix4x4_row_multiply_core: match");
    end else begin
      $display("matrix4x4_row_multiply_core: mismatch");
    end
    $finish;
  end

  initial begin : drain
    prod_row_t got;
    prod_row_t want;
    int        hold;
    int        n_res;
    bit        burst;
    out_stall <= 1'b0;
    hold  = 0;
    n_res = 0;
    burst = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = '{out_row, {prod_0, prod_1, prod_2, prod_3}, saturated};
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected transaction, row %0d", $time, got.row);
          err_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (got.row !== want.row) begin
            $display("%0t: out_row expected %0d got %0d", $time, want.row, got.row);
            err_cnt++;
          end
          for (int j = 0; j < 4; j++) begin
            if (got.prod[j] !== want.prod[j]) begin
              $display("%0t: prod_%0d expected %h got %h", $time, j, want.prod[j],
                       got.prod[j]);
              err_cnt++;
            end
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b got %b", $time, want.sat, got.sat);
            err_cnt++;
          end
        end
        n_res++;
        if (n_res % 40 == 0) burst = ($urandom_range(0, 2) == 0);
        // long hold-off once, so the pipeline fills and backs up the input
        hold = (n_res == 300) ? 200 : (burst ? 0 : $urandom_range(0, 10));
      end
      out_stall <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("matrix4x4_row_multiply_core: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mrx_pkg.sv
hw/rtl/mrx_row_store.sv
hw/rtl/mrx_lane.sv
hw/rtl/mrx_merge.sv
hw/rtl/matrix4x4_row_multiply_core.sv
tb/tb.sv
